// ===== sv/pcg64_pkg.sv =====
// Shared types and constants for the PCG64 XSL-RR generator.
// No dependencies; used by the multiply-add unit and the top level.
package pcg64_pkg;

  // Operation codes carried in the request beat
  localparam logic [2:0] FUNC_RAW   = 3'd0;
  localparam logic [2:0] FUNC_BOUND = 3'd1;
  localparam logic [2:0] FUNC_REAL  = 3'd2;
  localparam logic [2:0] FUNC_ADV   = 3'd3;
  localparam logic [2:0] FUNC_SEED  = 3'd4;

  // Configuration register indexes
  localparam int unsigned CfgIdxW = 2;
  localparam logic [CfgIdxW-1:0] CFG_STATE_HI  = 2'd0;
  localparam logic [CfgIdxW-1:0] CFG_STATE_LO  = 2'd1;
  localparam logic [CfgIdxW-1:0] CFG_STREAM_HI = 2'd2;
  localparam logic [CfgIdxW-1:0] CFG_STREAM_LO = 2'd3;

  // LCG multiplier
  localparam logic [127:0] LCG_MULT = {64'd2549297995355413924, 64'd4865540595714422341};

  // Sequencer states
  typedef enum logic [7:0] {
    S_IDLE = 8'b0000_0001,
    S_DRAW = 8'b0000_0010,
    S_DIV  = 8'b0000_0100,
    S_NORM = 8'b0000_1000,
    S_RND  = 8'b0001_0000,
    S_PACK = 8'b0010_0000,
    S_ADV  = 8'b0100_0000,
    S_DONE = 8'b1000_0000
  } state_e;

  // Steps of one jump-ahead bit
  typedef enum logic [4:0] {
    A_ACCM = 5'b00001,
    A_ACCP = 5'b00010,
    A_CURP = 5'b00100,
    A_CURM = 5'b01000,
    A_FIN  = 5'b10000
  } adv_e;

  // Multiply-add request and response
  typedef struct packed {
    logic         start;
    logic [127:0] a;
    logic [127:0] b;
    logic [127:0] c;
  } mac_req_t;

  typedef struct packed {
    logic         done;
    logic [127:0] result;
  } mac_rsp_t;

endpackage

// ===== sv/pcg64_req_if.sv =====
// Request channel of the PCG64 generator: operation and its operands.
// Depends on nothing.
interface pcg64_req_if;
  logic        valid;
  logic        ready;
  logic [2:0]  func;
  logic [63:0] bound;
  logic [63:0] jump_high;
  logic [63:0] jump_low;

  modport source (output valid, func, bound, jump_high, jump_low, input ready);
  modport sink (input valid, func, bound, jump_high, jump_low, output ready);
endinterface

// ===== sv/pcg64_rsp_if.sv =====
// Response channel of the PCG64 generator: result word and status.
// Depends on nothing.
interface pcg64_rsp_if;
  logic        valid;
  logic        ready;
  logic [63:0] value;
  logic        status;

  modport source (output valid, value, status, input ready);
  modport sink (input valid, value, status, output ready);
endinterface

// ===== sv/pcg64_mac.sv =====
// Iterative 128-bit multiply-add: result = a * b + c modulo 2^128.
// One 32x32 multiplier over ten limb products; uses pcg64_pkg structs.
module pcg64_mac (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  pcg64_pkg::mac_req_t req_i,
  output pcg64_pkg::mac_rsp_t rsp_o
);

  localparam logic [3:0] NumProd = 4'd10;

  logic [127:0] a_q, a_d, b_q, b_d, acc_q, acc_d;
  logic [63:0]  prod_q, prod_d;
  logic [1:0]   sh_q, sh_d;
  logic         pv_q, pv_d;
  logic [3:0]   k_q, k_d;
  logic         busy_q, busy_d;
  logic         done_q, done_d;
  logic [1:0]   li, lj;
  logic [127:0] addend;

  // Map the product number to its limb pair (only pairs with i + j < 4 matter)
  always_comb begin
    unique case (k_q)
      4'd0:    begin li = 2'd0; lj = 2'd0; end
      4'd1:    begin li = 2'd0; lj = 2'd1; end
      4'd2:    begin li = 2'd1; lj = 2'd0; end
      4'd3:    begin li = 2'd0; lj = 2'd2; end
      4'd4:    begin li = 2'd1; lj = 2'd1; end
      4'd5:    begin li = 2'd2; lj = 2'd0; end
      4'd6:    begin li = 2'd0; lj = 2'd3; end
      4'd7:    begin li = 2'd1; lj = 2'd2; end
      4'd8:    begin li = 2'd2; lj = 2'd1; end
      4'd9:    begin li = 2'd3; lj = 2'd0; end
      default: begin li = 2'd0; lj = 2'd0; end
    endcase
  end

  assign addend = {64'd0, prod_q} << {sh_q, 5'd0};

  // Issue one product a cycle, accumulate it the cycle after
  always_comb begin
    a_d    = a_q;
    b_d    = b_q;
    acc_d  = acc_q;
    prod_d = prod_q;
    sh_d   = sh_q;
    pv_d   = 1'b0;
    k_d    = k_q;
    busy_d = busy_q;
    done_d = 1'b0;
    if (pv_q) begin
      acc_d = acc_q + addend;
    end
    if (req_i.start) begin
      a_d    = req_i.a;
      b_d    = req_i.b;
      acc_d  = req_i.c;
      k_d    = 4'd0;
      busy_d = 1'b1;
    end else if (busy_q) begin
      if (k_q < NumProd) begin
        prod_d = 64'(a_q[32*li +: 32]) * 64'(b_q[32*lj +: 32]);
        sh_d   = li + lj;
        pv_d   = 1'b1;
        k_d    = k_q + 4'd1;
      end else begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      a_q    <= '0;
      b_q    <= '0;
      acc_q  <= '0;
      prod_q <= '0;
      sh_q   <= '0;
      pv_q   <= 1'b0;
      k_q    <= '0;
      busy_q <= 1'b0;
      done_q <= 1'b0;
    end else begin
      a_q    <= a_d;
      b_q    <= b_d;
      acc_q  <= acc_d;
      prod_q <= prod_d;
      sh_q   <= sh_d;
      pv_q   <= pv_d;
      k_q    <= k_d;
      busy_q <= busy_d;
      done_q <= done_d;
    end
  end

  assign rsp_o.done   = done_q;
  assign rsp_o.result = acc_q;

  // A product is only accumulated while a request is in flight
  a_pv_busy: assert property (@(posedge clk_i) disable iff (!rst_ni) pv_q |-> busy_q)
    else $error("product pending outside a request");
  // Done follows the last accumulate
  a_done_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_q |-> $past(busy_q) && $past(k_q) == NumProd)
    else $error("done without all products");
  // Done is a single-cycle pulse
  a_done_pulse: assert property (@(posedge clk_i) disable iff (!rst_ni) done_q |=> !done_q)
    else $error("done held for more than one cycle");

endmodule

// ===== sv/pcg64_xsl_rr_generator.sv =====
// PCG64 (128-bit LCG, XSL-RR output) served one request at a time. Every LCG step runs
// on a shared iterative 128-bit multiply-add built on one 32x32 multiplier; a raw draw
// or a seed is one such step. A bounded draw adds two bit-serial remainders (threshold
// and final modulo) around one or more draws. A real draw takes one draw per leading
// zero word plus, when the first nonzero word has a leading zero, a one-bit-a-cycle
// normalize and a second draw. An advance runs the CURP and CURM steps for every bit
// of the jump distance up to its highest set bit, the ACCM and ACCP steps as well for
// each set bit, plus one final step.
// Depends on pcg64_pkg, pcg64_req_if, pcg64_rsp_if and pcg64_mac.
module pcg64_xsl_rr_generator (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             cfg_we_i,
  input  logic [pcg64_pkg::CfgIdxW-1:0]    cfg_idx_i,
  input  logic [63:0]                      cfg_data_i,
  pcg64_req_if.sink                        req_if,
  pcg64_rsp_if.source                      rsp_if
);

  pcg64_pkg::state_e st_q, st_d;
  pcg64_pkg::adv_e   sub_q, sub_d;

  logic [63:0]  seed_sh_q, seed_sl_q, strm_sh_q, strm_sl_q;
  logic [127:0] lcg_q, lcg_d, inc_q, inc_d;
  logic [2:0]   op_q, op_d;
  logic [63:0]  bound_q, bound_d, thr_q, thr_d;
  logic         phase_q, phase_d, issued_q, issued_d;
  logic [63:0]  num_q, num_d, rem_q, rem_d;
  logic [5:0]   cnt_q, cnt_d;
  logic [63:0]  sig_q, sig_d;
  logic [5:0]   shift_q, shift_d;
  logic signed [11:0] exp_q, exp_d, e_q, e_d;
  logic [52:0]  top_q, top_d;
  logic [127:0] am_q, am_d, ap_q, ap_d, cm_q, cm_d, cp_q, cp_d, dist_q, dist_d;
  logic [63:0]  res_val_q, res_val_d;
  logic         res_st_q, res_st_d;
  logic         out_valid_q;
  logic [63:0]  out_val_q;
  logic         out_st_q;
  logic         out_load;

  pcg64_pkg::mac_req_t mac_req;
  pcg64_pkg::mac_rsp_t mac_rsp;
  logic                mac_start;

  logic [63:0]  xs, word;
  logic [64:0]  rem2;
  logic [63:0]  rem_new;
  logic [63:0]  s1;
  logic         rnd_up;
  logic [53:0]  t54;
  logic signed [11:0] e_r, e_lo;
  logic [63:0]  q_sub, lost, half, mask;
  logic [5:0]   ssh;

  pcg64_mac u_mac (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (mac_req),
    .rsp_o  (mac_rsp)
  );

  // Output word of the freshly stepped state
  assign xs   = mac_rsp.result[127:64] ^ mac_rsp.result[63:0];
  assign word = 64'({xs, xs} >> mac_rsp.result[127:122]);

  // One restoring remainder step
  assign rem2    = {rem_q, num_q[63]};
  assign rem_new = (rem2 >= {1'b0, bound_q}) ? 64'(rem2 - {1'b0, bound_q}) : rem2[63:0];

  // Round the 64-bit significand to 53 bits, nearest even with sticky bit
  assign s1     = sig_q | 64'd1;
  assign rnd_up = (s1[10:0] > 11'h400) || (s1[10:0] == 11'h400 && s1[11]);
  assign t54    = {1'b0, s1[63:11]} + {53'd0, rnd_up};
  assign e_r    = exp_q + 12'sd63;

  // Subnormal rounding
  assign e_lo  = -12'sd1022 - e_q;
  assign ssh   = e_lo[5:0];
  assign q_sub = {11'd0, top_q} >> ssh;
  assign mask  = (64'd1 << ssh) - 64'd1;
  assign lost  = {11'd0, top_q} & mask;
  assign half  = 64'd1 << (ssh - 6'd1);

  assign out_load     = (st_q == pcg64_pkg::S_DONE) && (!out_valid_q || rsp_if.ready);
  assign req_if.ready = (st_q == pcg64_pkg::S_IDLE);

  // Multiply-add operands for the current step
  always_comb begin
    mac_req.start = mac_start;
    mac_req.a = lcg_q;
    mac_req.b = pcg64_pkg::LCG_MULT;
    mac_req.c = inc_q;
    if (st_q == pcg64_pkg::S_ADV) begin
      unique case (sub_q)
        pcg64_pkg::A_ACCM: begin mac_req.a = am_q; mac_req.b = cm_q; mac_req.c = '0; end
        pcg64_pkg::A_ACCP: begin mac_req.a = ap_q; mac_req.b = cm_q; mac_req.c = cp_q; end
        pcg64_pkg::A_CURP: begin
          mac_req.a = cm_q + 128'd1; mac_req.b = cp_q; mac_req.c = '0;
        end
        pcg64_pkg::A_CURM: begin mac_req.a = cm_q; mac_req.b = cm_q; mac_req.c = '0; end
        pcg64_pkg::A_FIN:  begin mac_req.a = am_q; mac_req.b = lcg_q; mac_req.c = ap_q; end
        default: begin mac_req.a = am_q; mac_req.b = cm_q; mac_req.c = '0; end
      endcase
    end
  end

  // Sequencer
  always_comb begin
    st_d      = st_q;
    sub_d     = sub_q;
    lcg_d     = lcg_q;
    inc_d     = inc_q;
    op_d      = op_q;
    bound_d   = bound_q;
    thr_d     = thr_q;
    phase_d   = phase_q;
    issued_d  = issued_q;
    num_d     = num_q;
    rem_d     = rem_q;
    cnt_d     = cnt_q;
    sig_d     = sig_q;
    shift_d   = shift_q;
    exp_d     = exp_q;
    e_d       = e_q;
    top_d     = top_q;
    am_d      = am_q;
    ap_d      = ap_q;
    cm_d      = cm_q;
    cp_d      = cp_q;
    dist_d    = dist_q;
    res_val_d = res_val_q;
    res_st_d  = res_st_q;
    mac_start = 1'b0;

    unique case (st_q)
      pcg64_pkg::S_IDLE: begin
        if (req_if.valid) begin
          op_d      = req_if.func;
          bound_d   = req_if.bound;
          issued_d  = 1'b0;
          phase_d   = 1'b0;
          res_val_d = '0;
          res_st_d  = 1'b0;
          priority if (req_if.func == pcg64_pkg::FUNC_RAW) begin
            st_d = pcg64_pkg::S_DRAW;
          end else if (req_if.func == pcg64_pkg::FUNC_BOUND) begin
            if (req_if.bound == 64'd0) begin
              res_st_d = 1'b1;
              st_d     = pcg64_pkg::S_DONE;
            end else begin
              num_d = 64'd0 - req_if.bound;
              rem_d = '0;
              cnt_d = '0;
              st_d  = pcg64_pkg::S_DIV;
            end
          end else if (req_if.func == pcg64_pkg::FUNC_REAL) begin
            exp_d   = -12'sd64;
            shift_d = '0;
            st_d    = pcg64_pkg::S_DRAW;
          end else if (req_if.func == pcg64_pkg::FUNC_ADV) begin
            am_d   = 128'd1;
            ap_d   = '0;
            cm_d   = pcg64_pkg::LCG_MULT;
            cp_d   = inc_q;
            dist_d = {req_if.jump_high, req_if.jump_low};
            sub_d  = pcg64_pkg::A_ACCM;
            st_d   = pcg64_pkg::S_ADV;
          end else if (req_if.func == pcg64_pkg::FUNC_SEED) begin
            inc_d = {strm_sh_q[62:0], strm_sl_q, 1'b1};
            lcg_d = {strm_sh_q[62:0], strm_sl_q, 1'b1} + {seed_sh_q, seed_sl_q};
            st_d  = pcg64_pkg::S_DRAW;
          end else begin
            st_d = pcg64_pkg::S_DONE;
          end
        end
      end

      pcg64_pkg::S_DRAW: begin
        if (!issued_q) begin
          mac_start = 1'b1;
          issued_d  = 1'b1;
        end else if (mac_rsp.done) begin
          issued_d = 1'b0;
          lcg_d    = mac_rsp.result;
          priority if (op_q == pcg64_pkg::FUNC_RAW) begin
            res_val_d = word;
            st_d      = pcg64_pkg::S_DONE;
          end else if (op_q == pcg64_pkg::FUNC_BOUND) begin
            // Reject draws below the threshold, else reduce modulo bound
            if (word >= thr_q) begin
              num_d   = word;
              rem_d   = '0;
              cnt_d   = '0;
              phase_d = 1'b1;
              st_d    = pcg64_pkg::S_DIV;
            end
          end else if (op_q == pcg64_pkg::FUNC_REAL) begin
            if (phase_q) begin
              sig_d = sig_q | 64'(word >> (7'd64 - {1'b0, shift_q}));
              st_d  = pcg64_pkg::S_RND;
            end else if (word == 64'd0) begin
              exp_d = exp_q - 12'sd64;
              if (exp_q - 12'sd64 < -12'sd1074) begin
                st_d = pcg64_pkg::S_DONE;
              end
            end else begin
              sig_d = word;
              st_d  = word[63] ? pcg64_pkg::S_RND : pcg64_pkg::S_NORM;
            end
          end else begin
            st_d = pcg64_pkg::S_DONE;
          end
        end
      end

      pcg64_pkg::S_DIV: begin
        num_d = {num_q[62:0], 1'b0};
        rem_d = rem_new;
        cnt_d = cnt_q + 6'd1;
        if (cnt_q == 6'd63) begin
          if (phase_q) begin
            res_val_d = rem_new;
            st_d      = pcg64_pkg::S_DONE;
          end else begin
            thr_d = rem_new;
            st_d  = pcg64_pkg::S_DRAW;
          end
        end
      end

      pcg64_pkg::S_NORM: begin
        // Shift out one leading zero a cycle
        if (sig_q[63]) begin
          phase_d = 1'b1;
          st_d    = pcg64_pkg::S_DRAW;
        end else begin
          sig_d   = {sig_q[62:0], 1'b0};
          shift_d = shift_q + 6'd1;
          exp_d   = exp_q - 12'sd1;
        end
      end

      pcg64_pkg::S_RND: begin
        if (t54[53]) begin
          top_d = t54[53:1];
          e_d   = e_r + 12'sd1;
        end else begin
          top_d = t54[52:0];
          e_d   = e_r;
        end
        st_d = pcg64_pkg::S_PACK;
      end

      pcg64_pkg::S_PACK: begin
        if (e_q >= -12'sd1022) begin
          res_val_d = {1'b0, 11'(e_q + 12'sd1023), top_q[51:0]};
        end else if (e_lo >= 12'sd64) begin
          res_val_d = '0;
        end else if (lost > half || (lost == half && q_sub[0])) begin
          res_val_d = q_sub + 64'd1;
        end else begin
          res_val_d = q_sub;
        end
        st_d = pcg64_pkg::S_DONE;
      end

      pcg64_pkg::S_ADV: begin
        if (!issued_q) begin
          if (sub_q == pcg64_pkg::A_ACCM && dist_q == 128'd0) begin
            sub_d = pcg64_pkg::A_FIN;
          end else if (sub_q == pcg64_pkg::A_ACCM && !dist_q[0]) begin
            sub_d = pcg64_pkg::A_CURP;
          end else begin
            mac_start = 1'b1;
            issued_d  = 1'b1;
          end
        end else if (mac_rsp.done) begin
          issued_d = 1'b0;
          unique case (sub_q)
            pcg64_pkg::A_ACCM: begin am_d = mac_rsp.result; sub_d = pcg64_pkg::A_ACCP; end
            pcg64_pkg::A_ACCP: begin ap_d = mac_rsp.result; sub_d = pcg64_pkg::A_CURP; end
            pcg64_pkg::A_CURP: begin cp_d = mac_rsp.result; sub_d = pcg64_pkg::A_CURM; end
            pcg64_pkg::A_CURM: begin
              cm_d   = mac_rsp.result;
              dist_d = {1'b0, dist_q[127:1]};
              sub_d  = pcg64_pkg::A_ACCM;
            end
            pcg64_pkg::A_FIN: begin
              lcg_d = mac_rsp.result;
              st_d  = pcg64_pkg::S_DONE;
            end
            default: sub_d = pcg64_pkg::A_ACCM;
          endcase
        end
      end

      pcg64_pkg::S_DONE: begin
        if (out_load) begin
          st_d = pcg64_pkg::S_IDLE;
        end
      end

      default: st_d = pcg64_pkg::S_IDLE;
    endcase
  end

  // Hold configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      seed_sh_q <= '0;
      seed_sl_q <= '0;
      strm_sh_q <= '0;
      strm_sl_q <= '0;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        pcg64_pkg::CFG_STATE_HI:  seed_sh_q <= cfg_data_i;
        pcg64_pkg::CFG_STATE_LO:  seed_sl_q <= cfg_data_i;
        pcg64_pkg::CFG_STREAM_HI: strm_sh_q <= cfg_data_i;
        pcg64_pkg::CFG_STREAM_LO: strm_sl_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // Advance sequencer and working registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q      <= pcg64_pkg::S_IDLE;
      sub_q     <= pcg64_pkg::A_ACCM;
      lcg_q     <= '0;
      inc_q     <= 128'd1;
      op_q      <= '0;
      bound_q   <= '0;
      thr_q     <= '0;
      phase_q   <= 1'b0;
      issued_q  <= 1'b0;
      num_q     <= '0;
      rem_q     <= '0;
      cnt_q     <= '0;
      sig_q     <= '0;
      shift_q   <= '0;
      exp_q     <= '0;
      e_q       <= '0;
      top_q     <= '0;
      am_q      <= '0;
      ap_q      <= '0;
      cm_q      <= '0;
      cp_q      <= '0;
      dist_q    <= '0;
      res_val_q <= '0;
      res_st_q  <= 1'b0;
    end else begin
      st_q      <= st_d;
      sub_q     <= sub_d;
      lcg_q     <= lcg_d;
      inc_q     <= inc_d;
      op_q      <= op_d;
      bound_q   <= bound_d;
      thr_q     <= thr_d;
      phase_q   <= phase_d;
      issued_q  <= issued_d;
      num_q     <= num_d;
      rem_q     <= rem_d;
      cnt_q     <= cnt_d;
      sig_q     <= sig_d;
      shift_q   <= shift_d;
      exp_q     <= exp_d;
      e_q       <= e_d;
      top_q     <= top_d;
      am_q      <= am_d;
      ap_q      <= ap_d;
      cm_q      <= cm_d;
      cp_q      <= cp_d;
      dist_q    <= dist_d;
      res_val_q <= res_val_d;
      res_st_q  <= res_st_d;
    end
  end

  // Output register: load a finished result, drop it once taken
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
      out_val_q   <= '0;
      out_st_q    <= 1'b0;
    end else if (out_load) begin
      out_valid_q <= 1'b1;
      out_val_q   <= res_val_q;
      out_st_q    <= res_st_q;
    end else if (rsp_if.ready) begin
      out_valid_q <= 1'b0;
    end
  end

  assign rsp_if.valid  = out_valid_q;
  assign rsp_if.value  = out_val_q;
  assign rsp_if.status = out_st_q;

  // Every accepted beat starts work
  a_accept_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    req_if.valid && req_if.ready |=> st_q != pcg64_pkg::S_IDLE)
    else $error("accepted beat left the sequencer idle");
  // The increment stays odd
  a_inc_odd: assert property (@(posedge clk_i) disable iff (!rst_ni) inc_q[0])
    else $error("LCG increment became even");
  // Multiply-add results arrive only in states that wait for them
  a_mac_owner: assert property (@(posedge clk_i) disable iff (!rst_ni)
    mac_rsp.done |-> (st_q == pcg64_pkg::S_DRAW || st_q == pcg64_pkg::S_ADV))
    else $error("multiply-add result with no consumer");

endmodule
